/* design/spq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the stable priority queue
// Field widths, command and status codes, the control word broadcast to the
// cell chain, and the sequencer states.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int VALUE_W       = 32;
   localparam int PRIO_W        = 8;
   localparam int CMD_W         = 2;
   localparam int STATUS_W      = 2;
   localparam int DEPTH_DEFAULT = 16;

   typedef enum logic [CMD_W-1:0] {
      CMD_ENQUEUE = 2'd0,
      CMD_DEQUEUE = 2'd1,
      CMD_UPDATE  = 2'd2,
      CMD_NOP     = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK      = 2'd0,
      STAT_EMPTY   = 2'd1,
      STAT_FULL    = 2'd2,
      STAT_BAD_POS = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE
   } cell_op_type;

   // control word seen by every cell in the chain
   typedef struct packed {
      cell_op_type               op;
      logic signed [VALUE_W-1:0] value;
      logic [PRIO_W-1:0]         prio;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_REINSERT,
      S_SETTLE,
      S_DONE
   } state_type;

endpackage

/* design/stable_priority_queue_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_queue_unit: sorted-chain priority queue, FIFO among ties
// Keeps up to DEPTH entries ordered by priority in a row of cells.
// ----------------------------------------------------------------------------
// One item is in work at a time. Enqueue, dequeue, no-op and rejected items
// go from acceptance through the settle state to the done state, where the
// result is loaded into the output register; update-priority first passes
// through the reinsert state, since the entry is first taken out of the
// chain and then inserted again. The settle state lets the registered
// maximum tree that finds the largest value held follow a change of the
// cells. req_tready is high again in the cycle after the result is loaded
// into the output register, even while that result still waits for rsp_tready.
// ----------------------------------------------------------------------------
module stable_priority_queue_unit
   import spq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   localparam int IW     = $clog2(DEPTH),
   localparam int CW     = $clog2(DEPTH + 1),
   localparam int LEVELS = $clog2(DEPTH),
   localparam int LW     = $clog2(LEVELS + 1),
   localparam int REQ_W  = ((VALUE_W + PRIO_W + IW + 7) / 8) * 8,
   localparam int RSP_W  = ((4 * VALUE_W + PRIO_W + CW + 7) / 8) * 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // item_value, item_priority, position (from bit 0 up)
   input  logic [REQ_W-1:0]    req_tdata,
   // cmd
   input  logic [CMD_W-1:0]    req_tuser,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // removed_value, removed_priority, front_value, rear_value,
   // largest_value, occupancy (from bit 0 up)
   output logic [RSP_W-1:0]    rsp_tdata,
   // status
   output logic [STATUS_W-1:0] rsp_tuser
);

   // request fields
   cmd_type                   req_cmd;
   logic signed [VALUE_W-1:0] req_value;
   logic [PRIO_W-1:0]         req_prio;
   logic [IW-1:0]             req_pos;

   assign req_cmd   = cmd_type'(req_tuser);
   assign req_value = $signed(req_tdata[VALUE_W-1:0]);
   assign req_prio  = req_tdata[VALUE_W +: PRIO_W];
   assign req_pos   = req_tdata[VALUE_W+PRIO_W +: IW];

   // sequencer and payload registers
   state_type                 state_ff, state_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [LW-1:0]             wait_ff, wait_in;
   status_type                status_ff, status_in;
   logic signed [VALUE_W-1:0] rem_value_ff, rem_value_in;
   logic [PRIO_W-1:0]         rem_prio_ff, rem_prio_in;
   logic signed [VALUE_W-1:0] keep_value_ff, keep_value_in;
   logic [PRIO_W-1:0]         keep_prio_ff, keep_prio_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]          rsp_data_ff, rsp_data_in;
   logic [STATUS_W-1:0]       rsp_user_ff, rsp_user_in;

   // cell chain
   cell_ctl_type              ctl;
   logic [IW-1:0]             ctl_pos;
   logic                      cell_occ   [DEPTH];
   logic                      cell_keep  [DEPTH];
   logic signed [VALUE_W-1:0] cell_value [DEPTH];
   logic [PRIO_W-1:0]         cell_prio  [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                      l_keep;
      logic signed [VALUE_W-1:0] l_value, r_value;
      logic [PRIO_W-1:0]         l_prio, r_prio;

      assign cell_occ[i] = CW'(i) < count_ff;

      if (i == 0) begin : g_head
         assign l_keep  = 1'b1;
         assign l_value = ctl.value;
         assign l_prio  = ctl.prio;
      end else begin : g_body
         assign l_keep  = cell_keep[i-1];
         assign l_value = cell_value[i-1];
         assign l_prio  = cell_prio[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign r_value = cell_value[i];
         assign r_prio  = cell_prio[i];
      end else begin : g_mid
         assign r_value = cell_value[i+1];
         assign r_prio  = cell_prio[i+1];
      end

      spq_cell #(
         .DEPTH (DEPTH),
         .IDX   (i)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .pos         (ctl_pos),
         .occupied    (cell_occ[i]),
         .left_keep   (l_keep),
         .left_value  (l_value),
         .left_prio   (l_prio),
         .right_value (r_value),
         .right_prio  (r_prio),
         .keep        (cell_keep[i]),
         .value       (cell_value[i]),
         .prio        (cell_prio[i])
      );
   end

   // largest value held
   logic                      root_valid;
   logic signed [VALUE_W-1:0] root_value;

   spq_max_tree #(
      .DEPTH (DEPTH)
   ) u_max_tree (
      .clock      (clock),
      .reset      (reset),
      .leaf_valid (cell_occ),
      .leaf_value (cell_value),
      .root_valid (root_valid),
      .root_value (root_value)
   );

   // pick the entry at the requested position and the tail entry
   logic signed [VALUE_W-1:0] pos_value;
   logic signed [VALUE_W-1:0] rear_value;
   logic [CW-1:0]             rear_idx;

   assign rear_idx = count_ff - CW'(1);

   always_comb begin
      pos_value  = '0;
      rear_value = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (IW'(i) == req_pos) begin
            pos_value = pos_value | cell_value[i];
         end
         if (CW'(i) == rear_idx) begin
            rear_value = rear_value | cell_value[i];
         end
      end
   end

   // result fields
   logic signed [VALUE_W-1:0] front_value;
   logic signed [VALUE_W-1:0] largest_value;

   assign front_value   = (count_ff != '0) ? cell_value[0] : '0;
   assign largest_value = root_valid ? root_value : '0;

   // next state, cell control and outputs
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      wait_in       = wait_ff;
      status_in     = status_ff;
      rem_value_in  = rem_value_ff;
      rem_prio_in   = rem_prio_ff;
      keep_value_in = keep_value_ff;
      keep_prio_in  = keep_prio_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      req_tready    = 1'b0;
      ctl.op        = CELL_HOLD;
      ctl.value     = req_value;
      ctl.prio      = req_prio;
      ctl_pos       = req_pos;

      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               status_in    = STAT_OK;
               rem_value_in = '0;
               rem_prio_in  = '0;
               wait_in      = LW'(LEVELS - 1);
               state_in     = S_SETTLE;
               case (req_cmd)
                  CMD_ENQUEUE: begin
                     if (count_ff == CW'(DEPTH)) begin
                        status_in = STAT_FULL;
                     end else begin
                        ctl.op   = CELL_INSERT;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  CMD_DEQUEUE: begin
                     if (count_ff == '0) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        rem_value_in = cell_value[0];
                        rem_prio_in  = cell_prio[0];
                        ctl.op       = CELL_REMOVE;
                        ctl_pos      = '0;
                        count_in     = count_ff - CW'(1);
                     end
                  end
                  CMD_UPDATE: begin
                     if (count_ff == '0) begin
                        status_in = STAT_EMPTY;
                     end else if (CW'(req_pos) >= count_ff) begin
                        status_in = STAT_BAD_POS;
                     end else begin
                        // take the entry out now, insert it next cycle
                        keep_value_in = pos_value;
                        keep_prio_in  = req_prio;
                        ctl.op        = CELL_REMOVE;
                        count_in      = count_ff - CW'(1);
                        state_in      = S_REINSERT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_REINSERT: begin
            ctl.op    = CELL_INSERT;
            ctl.value = keep_value_ff;
            ctl.prio  = keep_prio_ff;
            count_in  = count_ff + CW'(1);
            state_in  = S_SETTLE;
         end
         S_SETTLE: begin
            // let the maximum tree catch up with the cells
            if (wait_ff == '0) begin
               state_in = S_DONE;
            end else begin
               wait_in = wait_ff - LW'(1);
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = status_ff;
               rsp_data_in  = RSP_W'({count_ff, largest_value, rear_value,
                                      front_value, rem_prio_ff, rem_value_ff});
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         wait_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         wait_ff      <= wait_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      status_ff     <= status_in;
      rem_value_ff  <= rem_value_in;
      rem_prio_ff   <= rem_prio_in;
      keep_value_ff <= keep_value_in;
      keep_prio_ff  <= keep_prio_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_user_ff   <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

/* design/spq_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one entry and, per cycle, keeps it, takes the new item, takes the
// entry of its left neighbor (insert shift) or of its right neighbor (remove).
// ----------------------------------------------------------------------------
module spq_cell
   import spq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   parameter int IDX   = 0,
   localparam int IW   = $clog2(DEPTH)
) (
   input  logic                      clock,
   input  cell_ctl_type              ctl,
   input  logic [IW-1:0]             pos,
   input  logic                      occupied,
   input  logic                      left_keep,
   input  logic signed [VALUE_W-1:0] left_value,
   input  logic [PRIO_W-1:0]         left_prio,
   input  logic signed [VALUE_W-1:0] right_value,
   input  logic [PRIO_W-1:0]         right_prio,
   output logic                      keep,
   output logic signed [VALUE_W-1:0] value,
   output logic [PRIO_W-1:0]         prio
);

   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic [PRIO_W-1:0]         prio_ff, prio_in;

   // entry stays put on insert when it ranks the same or higher
   assign keep = occupied && (prio_ff >= ctl.prio);

   // choose next content
   always_comb begin
      value_in = value_ff;
      prio_in  = prio_ff;
      case (ctl.op)
         CELL_INSERT: begin
            if (!keep) begin
               if (left_keep) begin
                  value_in = ctl.value;
                  prio_in  = ctl.prio;
               end else begin
                  value_in = left_value;
                  prio_in  = left_prio;
               end
            end
         end
         CELL_REMOVE: begin
            if (IW'(IDX) >= pos) begin
               value_in = right_value;
               prio_in  = right_prio;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      prio_ff  <= prio_in;
   end

   assign value = value_ff;
   assign prio  = prio_ff;

endmodule

/* design/spq_max_tree.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_max_tree: registered signed-maximum tree over the cell chain
// One register level per tree level; the root follows the leaves through
// these registers. Invalid leaves never win.
// ----------------------------------------------------------------------------
module spq_max_tree
   import spq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   localparam int LEVELS = $clog2(DEPTH),
   localparam int NP     = 1 << LEVELS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      leaf_valid [DEPTH],
   input  logic signed [VALUE_W-1:0] leaf_value [DEPTH],
   output logic                      root_valid,
   output logic signed [VALUE_W-1:0] root_value
);

   logic                      node_valid [1:2*NP-1];
   logic signed [VALUE_W-1:0] node_value [1:2*NP-1];

   // leaves, padded out to a power of two
   for (genvar j = 0; j < NP; j++) begin : g_leaf
      if (j < DEPTH) begin : g_used
         assign node_valid[NP+j] = leaf_valid[j];
         assign node_value[NP+j] = leaf_value[j];
      end else begin : g_pad
         assign node_valid[NP+j] = 1'b0;
         assign node_value[NP+j] = '0;
      end
   end

   // inner nodes, each registered
   for (genvar k = 1; k < NP; k++) begin : g_node
      logic                      valid_ff, valid_in;
      logic signed [VALUE_W-1:0] value_ff, value_in;
      logic                      pick_right;

      assign pick_right = node_valid[2*k+1] &&
                          (!node_valid[2*k] || (node_value[2*k+1] > node_value[2*k]));
      assign valid_in   = node_valid[2*k] || node_valid[2*k+1];
      assign value_in   = pick_right ? node_value[2*k+1] : node_value[2*k];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else begin
            valid_ff <= valid_in;
         end
      end

      always_ff @(posedge clock) begin
         value_ff <= value_in;
      end

      assign node_valid[k] = valid_ff;
      assign node_value[k] = value_ff;
   end

   assign root_valid = node_valid[1];
   assign root_value = node_value[1];

endmodule
